// ===== hw/rtl/three_window_boxcar_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Three-window boxcar filter assertion macros
// Short forms for the concurrent assertions of the filter checker.
// ----------------------------------------------------------------------------
`ifndef THREE_WINDOW_BOXCAR_FILTER_MACROS_SVH
`define THREE_WINDOW_BOXCAR_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TBCF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TBCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that stays active during reset.
`define TBCF_ASSERT_RESET(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-window boxcar filter package
// Field widths, register indexes, tap numbering and shared types.
// ----------------------------------------------------------------------------
package tbcf_pkg;

   // Transaction field widths.
   localparam int SAMPLE_W = 14;
   localparam int RESP_W   = 25;
   localparam int LOBE_W   = 8;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOBE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_MODE  = 1'b1;
   localparam logic [LOBE_W-1:0] LOBE_RESET = 8'd2;

   // Default sizing.
   localparam int DEF_MAX_LOBE      = 128;
   localparam int DEF_HISTORY_DEPTH = 768;

   // Cumulative-sum taps: age n, age n+m and age 2n+m.
   localparam int NUM_TAPS = 3;
   localparam int TAP_MID  = 0;
   localparam int TAP_OLD  = 1;
   localparam int TAP_END  = 2;

   // Response saturation limits.
   localparam logic signed [RESP_W-1:0] RESP_MAX = {1'b0, {(RESP_W-1){1'b1}}};
   localparam logic signed [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

   // Per-transaction control that travels beside the RAM read.
   typedef struct packed {
      logic                slow_mode;
      logic [NUM_TAPS-1:0] tap_zero;
   } tbcf_tag_type;

endpackage

// ===== hw/rtl/tbcf_cum_ram.sv =====
// ----------------------------------------------------------------------------
// Cumulative-sum RAM
// One write port and a configurable number of registered read ports.
// ----------------------------------------------------------------------------
module tbcf_cum_ram #(
   parameter int DEPTH  = tbcf_pkg::DEF_HISTORY_DEPTH + 1,
   parameter int DATA_W = 25,
   parameter int READS  = 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr [READS],
   output logic [DATA_W-1:0] rd_data [READS]
);

   logic [DATA_W-1:0] ram_ff     [DEPTH];
   logic [DATA_W-1:0] rd_data_ff [READS];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports, data registered and held while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int i = 0; i < READS; i++) begin
            rd_data_ff[i] <= ram_ff[rd_addr[i]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tbcf_front.sv =====
// ----------------------------------------------------------------------------
// Boxcar filter front end
// Holds the configuration, the running cumulative sum, the ring slot and the
// fill count, and forms the RAM write and the three tap read addresses.
// ----------------------------------------------------------------------------
module tbcf_front #(
   parameter int MAX_LOBE      = tbcf_pkg::DEF_MAX_LOBE,
   parameter int HISTORY_DEPTH = tbcf_pkg::DEF_HISTORY_DEPTH,
   parameter int CUM_W         = tbcf_pkg::SAMPLE_W + $clog2(HISTORY_DEPTH) + 1,
   parameter int SLOT_W        = $clog2(HISTORY_DEPTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [tbcf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tbcf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   take,
   input  logic signed [tbcf_pkg::SAMPLE_W-1:0]   sample,
   input  logic                                   first,
   output logic [SLOT_W-1:0]                      wr_addr,
   output logic signed [CUM_W-1:0]                cum,
   output logic [SLOT_W-1:0]                      rd_addr [tbcf_pkg::NUM_TAPS],
   output tbcf_pkg::tbcf_tag_type                 tag
);

   import tbcf_pkg::*;

   // The ring keeps one entry more than the history so that the sum just
   // past the oldest kept sample is still there.
   localparam int RING   = HISTORY_DEPTH + 1;
   localparam int FILL_W = $clog2(RING + 1);
   localparam int K_W    = $clog2(6 * MAX_LOBE + 1);

   logic [LOBE_W-1:0]       lobe_ff, lobe_in;
   logic                    mode_ff, mode_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in, slot_new;
   logic [FILL_W-1:0]       fill_ff, fill_in, fill_new;
   logic signed [CUM_W-1:0] cum_ff, cum_in, cum_new, cum_base, sample_ext;
   logic [K_W-1:0]          n_age, m_age;
   logic [K_W-1:0]          tap_age [NUM_TAPS];
   logic [SLOT_W-1:0]       tap_eff [NUM_TAPS];

   // Configuration register writes.
   always_comb begin
      lobe_in = lobe_ff;
      mode_in = mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LOBE_WIDTH: begin
               lobe_in = csr_wdata[LOBE_W-1:0];
            end
            CSR_SLOW_MODE: begin
               mode_in = csr_wdata[0];
            end
            default: begin
               lobe_in = lobe_ff;
            end
         endcase
      end
   end

   // Lobe lengths: zero counts as one, large values clamp to the maximum.
   always_comb begin
      if (lobe_ff == '0) begin
         n_age = K_W'(1);
      end else if (32'(lobe_ff) > 32'(MAX_LOBE)) begin
         n_age = K_W'(MAX_LOBE);
      end else begin
         n_age = K_W'(lobe_ff);
      end
      m_age            = mode_ff ? (n_age << 2) : n_age;
      tap_age[TAP_MID] = n_age;
      tap_age[TAP_OLD] = n_age + m_age;
      tap_age[TAP_END] = n_age + m_age + n_age;
   end

   // Slot, fill count and cumulative sum after the incoming sample.
   assign sample_ext = CUM_W'(sample);
   assign cum_base   = first ? '0 : cum_ff;
   assign cum_new    = cum_base + sample_ext;

   always_comb begin
      if (first || slot_ff == SLOT_W'(RING - 1)) begin
         slot_new = '0;
      end else begin
         slot_new = slot_ff + SLOT_W'(1);
      end
      if (first) begin
         fill_new = FILL_W'(1);
      end else if (fill_ff == FILL_W'(RING)) begin
         fill_new = fill_ff;
      end else begin
         fill_new = fill_ff + FILL_W'(1);
      end
   end

   assign slot_in = take ? slot_new : slot_ff;
   assign fill_in = take ? fill_new : fill_ff;
   assign cum_in  = take ? cum_new  : cum_ff;

   // Tap addresses. A tap at or beyond the valid fill reads as zero.
   always_comb begin
      for (int i = 0; i < NUM_TAPS; i++) begin
         if (32'(tap_age[i]) > 32'(HISTORY_DEPTH)) begin
            tap_eff[i] = SLOT_W'(HISTORY_DEPTH);
         end else begin
            tap_eff[i] = SLOT_W'(tap_age[i]);
         end
         tag.tap_zero[i] = FILL_W'(tap_eff[i]) >= fill_new;
         if (slot_new >= tap_eff[i]) begin
            rd_addr[i] = slot_new - tap_eff[i];
         end else begin
            rd_addr[i] = SLOT_W'({1'b0, slot_new} + (SLOT_W + 1)'(RING) - {1'b0, tap_eff[i]});
         end
      end
      tag.slow_mode = mode_ff;
   end

   assign wr_addr = slot_new;
   assign cum     = cum_new;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lobe_ff <= LOBE_RESET;
         mode_ff <= 1'b0;
         slot_ff <= SLOT_W'(RING - 1);
         fill_ff <= '0;
         cum_ff  <= '0;
      end else begin
         lobe_ff <= lobe_in;
         mode_ff <= mode_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         cum_ff  <= cum_in;
      end
   end

endmodule

// ===== hw/rtl/tbcf_combine.sv =====
// ----------------------------------------------------------------------------
// Boxcar filter back end
// Turns the tap sums into window sums, weights them, saturates the response
// and holds it in the output register. Owns the pipeline flow control.
// ----------------------------------------------------------------------------
module tbcf_combine #(
   parameter int CUM_W = tbcf_pkg::SAMPLE_W + $clog2(tbcf_pkg::DEF_HISTORY_DEPTH) + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic signed [CUM_W-1:0]              cum,
   input  tbcf_pkg::tbcf_tag_type               tag,
   input  logic [CUM_W-1:0]                     tap_data [tbcf_pkg::NUM_TAPS],
   output logic                                 ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tbcf_pkg::RESP_W-1:0]   rsp_response
);

   import tbcf_pkg::*;

   localparam int WGT_W = CUM_W + 2;
   localparam int SAT_W = (WGT_W > RESP_W) ? WGT_W : RESP_W;

   logic                    s1_v_ff, s1_v_in;
   logic                    s2_v_ff, s2_v_in;
   logic                    out_v_ff, out_v_in;
   logic                    s1_adv, s2_adv, out_adv;
   logic signed [CUM_W-1:0] p0_ff;
   tbcf_tag_type            tag_ff;
   logic signed [CUM_W-1:0] tap_sum [NUM_TAPS];
   logic signed [CUM_W-1:0] newest, middle, oldest;
   logic signed [CUM_W-1:0] newest_ff, middle_ff, oldest_ff;
   logic                    slow_ff;
   logic signed [SAT_W-1:0] new_w, mid_w, old_w, weighted;
   logic signed [RESP_W-1:0] resp_sat;
   logic signed [RESP_W-1:0] rsp_response_ff;

   // Flow control: each stage moves when the one after it is empty or moving.
   assign out_adv = !out_v_ff || rsp_ready;
   assign s2_adv  = !s2_v_ff || out_adv;
   assign s1_adv  = !s1_v_ff || s2_adv;
   assign ready   = s1_adv;

   assign s1_v_in  = take || (s1_v_ff && !s2_adv);
   assign s2_v_in  = s2_adv ? s1_v_ff : s2_v_ff;
   assign out_v_in = out_adv ? s2_v_ff : out_v_ff;

   // Window sums from differences of cumulative sums, modulo the sum width.
   always_comb begin
      for (int i = 0; i < NUM_TAPS; i++) begin
         tap_sum[i] = tag_ff.tap_zero[i] ? '0 : $signed(tap_data[i]);
      end
      newest = p0_ff - tap_sum[TAP_MID];
      middle = tap_sum[TAP_MID] - tap_sum[TAP_OLD];
      oldest = tap_sum[TAP_OLD] - tap_sum[TAP_END];
   end

   // Lobe weighting and saturation to the response range.
   always_comb begin
      new_w = SAT_W'(newest_ff);
      mid_w = SAT_W'(middle_ff);
      old_w = SAT_W'(oldest_ff);
      if (slow_ff) begin
         weighted = mid_w - ((new_w + old_w) <<< 1);
      end else begin
         weighted = (mid_w <<< 1) - (new_w + old_w);
      end
      if (weighted > SAT_W'(RESP_MAX)) begin
         resp_sat = RESP_MAX;
      end else if (weighted < SAT_W'(RESP_MIN)) begin
         resp_sat = RESP_MIN;
      end else begin
         resp_sat = RESP_W'(weighted);
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         p0_ff  <= cum;
         tag_ff <= tag;
      end
      if (s2_adv && s1_v_ff) begin
         newest_ff <= newest;
         middle_ff <= middle;
         oldest_ff <= oldest;
         slow_ff   <= tag_ff.slow_mode;
      end
      if (out_adv && s2_v_ff) begin
         rsp_response_ff <= resp_sat;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_response = rsp_response_ff;

endmodule

// ===== hw/rtl/three_window_boxcar_filter.sv =====
// ----------------------------------------------------------------------------
// Three-window boxcar filter
// Streams signed samples and gives, per sample, the weighted difference of a
// middle window sum against the newest and oldest window sums.
//
//   Channel   Ports                               Direction   Content
//   req       req_valid/req_ready                 in          req_sample, req_first
//   rsp       rsp_valid/rsp_ready                 out         rsp_response
//   csr       csr_write_en/csr_index/csr_wdata    in          lobe_width, slow_pulse_mode
//
// One transaction per cycle sustained while the output is not stalled; a
// response is offered once its request has passed the tap-read, window-sum
// and output registers.
// Window sums come from a cumulative-sum ring held twice in RAM: one copy
// serves the two inner taps and one the outer tap, one read each per cycle.
// Reset clears the fill count, so no RAM clearing pass is needed.
// A stalled output holds the response; the request side keeps taking
// transactions until every pipeline stage is full.
// ----------------------------------------------------------------------------
module three_window_boxcar_filter #(
   parameter int MAX_LOBE      = tbcf_pkg::DEF_MAX_LOBE,
   parameter int HISTORY_DEPTH = tbcf_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tbcf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_first,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tbcf_pkg::RESP_W-1:0]   rsp_response,
   input  logic                                 csr_write_en,
   input  logic [tbcf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tbcf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import tbcf_pkg::*;

   localparam int RING   = HISTORY_DEPTH + 1;
   localparam int SLOT_W = $clog2(RING);
   localparam int CUM_W  = SAMPLE_W + $clog2(HISTORY_DEPTH) + 1;

   logic                    take;
   logic [SLOT_W-1:0]       wr_addr;
   logic signed [CUM_W-1:0] cum;
   logic [SLOT_W-1:0]       rd_addr [NUM_TAPS];
   tbcf_tag_type            tag;
   logic [SLOT_W-1:0]       ram_a_addr [2];
   logic [SLOT_W-1:0]       ram_b_addr [1];
   logic [CUM_W-1:0]        ram_a_data [2];
   logic [CUM_W-1:0]        ram_b_data [1];
   logic [CUM_W-1:0]        tap_data   [NUM_TAPS];

   assign take = req_valid && req_ready;

   // Front end: configuration, cumulative sum and tap addresses.
   tbcf_front #(
      .MAX_LOBE      (MAX_LOBE),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .CUM_W         (CUM_W),
      .SLOT_W        (SLOT_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .take         (take),
      .sample       (req_sample),
      .first        (req_first),
      .wr_addr      (wr_addr),
      .cum          (cum),
      .rd_addr      (rd_addr),
      .tag          (tag)
   );

   // Tap routing across the two RAM copies.
   assign ram_a_addr[0]     = rd_addr[TAP_MID];
   assign ram_a_addr[1]     = rd_addr[TAP_OLD];
   assign ram_b_addr[0]     = rd_addr[TAP_END];
   assign tap_data[TAP_MID] = ram_a_data[0];
   assign tap_data[TAP_OLD] = ram_a_data[1];
   assign tap_data[TAP_END] = ram_b_data[0];

   // Inner-tap copy of the cumulative-sum ring.
   tbcf_cum_ram #(
      .DEPTH  (RING),
      .DATA_W (CUM_W),
      .READS  (2),
      .ADDR_W (SLOT_W)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (wr_addr),
      .wr_data (cum),
      .rd_en   (take),
      .rd_addr (ram_a_addr),
      .rd_data (ram_a_data)
   );

   // Outer-tap copy of the cumulative-sum ring.
   tbcf_cum_ram #(
      .DEPTH  (RING),
      .DATA_W (CUM_W),
      .READS  (1),
      .ADDR_W (SLOT_W)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (wr_addr),
      .wr_data (cum),
      .rd_en   (take),
      .rd_addr (ram_b_addr),
      .rd_data (ram_b_data)
   );

   // Back end: window sums, weighting, saturation and output register.
   tbcf_combine #(
      .CUM_W (CUM_W)
   ) u_combine (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .cum          (cum),
      .tag          (tag),
      .tap_data     (tap_data),
      .ready        (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_response (rsp_response)
   );

endmodule

// ===== hw/rtl/tbcf_checker.sv =====
// ----------------------------------------------------------------------------
// Three-window boxcar filter checker
// Port-level assertions on the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "three_window_boxcar_filter_macros.svh"

module tbcf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [tbcf_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 req_first,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [tbcf_pkg::RESP_W-1:0]   rsp_response
);

   import tbcf_pkg::*;

   logic                     accept;
   logic signed [RESP_W-1:0] sample_ext;

   assign accept     = req_valid && req_ready;
   assign sample_ext = RESP_W'(req_sample);

   // Reset empties the output register.
   `TBCF_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid, "response valid after reset")

   // With no response waiting the whole pipeline can move.
   `TBCF_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "not ready while output empty")

   // A stalled response holds.
   `TBCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_response), "stalled response changed")

   // The first sample of a waveform only sees itself in the newest window.
   `TBCF_ASSERT_NEXT(a_first_sample, clock, reset, accept && req_first ##1 rsp_ready ##1 rsp_ready, rsp_valid && (rsp_response == -$past(sample_ext, 3) || rsp_response == -($past(sample_ext, 3) <<< 1)), "wrong response to first sample")

endmodule

bind three_window_boxcar_filter tbcf_checker u_tbcf_checker (.*);
